/* design/hcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcm_pkg: shared types, constants and arithmetic helpers
// Transaction types, controller states, datapath commands and the small
// mod-26 helper functions used by the Hill cipher block.
// ----------------------------------------------------------------------------
package hcm_pkg;

  // Field widths.
  localparam int unsigned CHAR_IN_W  = 8;
  localparam int unsigned CHAR_OUT_W = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned VAL_W      = 5;   // a residue 0..25
  localparam int unsigned SUM_W      = 11;  // dot product of three residues
  localparam int unsigned IDX_W      = 4;   // matrix entry 0..8

  // Arithmetic constants.
  localparam logic [VAL_W-1:0]      MOD_BASE = 5'd26;
  localparam logic [VAL_W-1:0]      PAD_VAL  = 5'd23;   // letter X
  localparam logic [CHAR_IN_W-1:0]  ASCII_A  = 8'd65;
  localparam logic [CHAR_IN_W-1:0]  ASCII_Z  = 8'd90;
  localparam logic [CHAR_IN_W-1:0]  CHAR_MOD = 8'd97;
  localparam logic [CHAR_OUT_W-1:0] OUT_A    = 7'd65;
  // floor(s * RECIP26 / 2^16) is s/26 or one less for every s below 2^11.
  localparam logic [11:0]           RECIP26  = 12'd2520;

  // Step counter limits.
  localparam logic [IDX_W-1:0] IDX_LAST_ENTRY = 4'd8;
  localparam logic [IDX_W-1:0] IDX_LAST_ROW   = 4'd2;
  localparam logic [1:0]       CNT_FULL       = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ROW0,
    REG_KEY_ROW1,
    REG_KEY_ROW2,
    REG_DECRYPT_MODE
  } cfg_reg_t;

  // Transaction payloads.
  typedef struct packed {
    logic [CHAR_IN_W-1:0] char_in;
    logic                 last_char;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_OUT_W-1:0] char_out;
    logic                  last_out;
    logic                  key_error;
  } out_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_COF_CALC,
    S_COF_STORE,
    S_DET_CALC,
    S_DET_STORE,
    S_INV_CALC,
    S_INV_STORE,
    S_ROW_CALC,
    S_ROW_STORE,
    S_ERR_OUT
  } ctl_state_t;

  // Dot-product unit operations.
  typedef enum logic [1:0] {
    OP_COF,
    OP_DET,
    OP_INV,
    OP_ROW
  } dp_op_t;

  // Controller to datapath.
  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
    logic             calc;     // latch the dot product
    logic             store;    // reduce and write the result
    logic             out_load; // load the output register
    logic             out_err;  // load the key error result
    logic             pend_wr;  // keep the character value
    logic             blk_ld;   // build the block vector
    logic [1:0]       cnt;      // values already gathered
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic decrypt;
    logic usable;
  } dp_sts_t;

  // Reduce a 5-bit key entry mod 26.
  function automatic logic [VAL_W-1:0] mod26_key(input logic [VAL_W-1:0] x);
    return (x >= MOD_BASE) ? x - MOD_BASE : x;
  endfunction

  // Additive inverse mod 26 of a residue.
  function automatic logic [VAL_W-1:0] neg26(input logic [VAL_W-1:0] x);
    return (x == '0) ? '0 : MOD_BASE - x;
  endfunction

  // Reduce a dot product mod 26 by reciprocal multiplication and one fixup.
  function automatic logic [VAL_W-1:0] mod26_sum(input logic [SUM_W-1:0] s);
    logic [22:0]      prod;
    logic [6:0]       q;
    logic [SUM_W-1:0] r;
    prod = 23'(s) * 23'(RECIP26);
    q    = prod[22:16];
    r    = s - 11'(11'(q) * 11'(MOD_BASE));
    if (r >= 11'(MOD_BASE)) begin
      r = r - 11'(MOD_BASE);
    end
    return r[VAL_W-1:0];
  endfunction

  // Character to residue: letters give c-65, other bytes c mod 97, then mod 26.
  function automatic logic [VAL_W-1:0] char_value(input logic [CHAR_IN_W-1:0] c);
    logic [6:0] v;
    if (c >= ASCII_A && c <= ASCII_Z) begin
      v = 7'(c - ASCII_A);
    end else if (c < CHAR_MOD) begin
      v = c[6:0];
    end else if (c < 8'(2 * CHAR_MOD)) begin
      v = 7'(c - CHAR_MOD);
    end else begin
      v = 7'(c - 8'(2 * CHAR_MOD));
    end
    if (v >= 7'(3 * MOD_BASE)) begin
      v = v - 7'(3 * MOD_BASE);
    end else if (v >= 7'(2 * MOD_BASE)) begin
      v = v - 7'(2 * MOD_BASE);
    end else if (v >= 7'(MOD_BASE)) begin
      v = v - 7'(MOD_BASE);
    end
    return v[VAL_W-1:0];
  endfunction

  // Multiplicative inverse mod 26; zero where none exists.
  function automatic logic [VAL_W-1:0] inv26(input logic [VAL_W-1:0] d);
    logic [VAL_W-1:0] r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/hcm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcm_datapath: key storage, matrix inversion and block multiply
// Holds the configuration registers, the cofactor and inverse matrices, the
// gathered character values and the output register. One shared unit forms
// a three-term dot product into the sum register, then reduces that mod 26.
// ----------------------------------------------------------------------------
module hcm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hcm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  hcm_pkg::in_item_t                   in_data,
  input  hcm_pkg::dp_cmd_t                    cmd,
  output hcm_pkg::dp_sts_t                    sts,
  output hcm_pkg::out_item_t                  out_data
);

  localparam int unsigned VW = hcm_pkg::VAL_W;

  logic [hcm_pkg::CFG_DATA_W-1:0] key_r [3];
  logic                           dec_r;
  logic [VW-1:0]                  kmat  [3][3];
  logic [VW-1:0]                  cof_r [3][3];
  logic [VW-1:0]                  inv_r [3][3];
  logic [VW-1:0]                  dinv_r;
  logic                           inv_ok_r;
  logic [VW-1:0]                  pend_r [2];
  logic [VW-1:0]                  vec_r  [3];
  logic                           last_r;
  logic [hcm_pkg::SUM_W-1:0]      sum_r;
  logic [hcm_pkg::SUM_W-1:0]      sum_nxt;
  hcm_pkg::out_item_t             out_r;

  logic [1:0]    ci, cj, r0, r1, c0, c1;
  logic [1:0]    row;
  logic          even;
  logic [VW-1:0] ka, kb, kc, kd;
  logic [VW-1:0] a0, b0, a1, b1, a2, b2;
  logic [9:0]    p0, p1, p2;
  logic [VW-1:0] red;
  logic [VW-1:0] cval;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= '0;
      key_r[1] <= '0;
      key_r[2] <= '0;
      dec_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        hcm_pkg::REG_KEY_ROW0:     key_r[0] <= cfg_wdata;
        hcm_pkg::REG_KEY_ROW1:     key_r[1] <= cfg_wdata;
        hcm_pkg::REG_KEY_ROW2:     key_r[2] <= cfg_wdata;
        hcm_pkg::REG_DECRYPT_MODE: dec_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Key matrix, each entry reduced mod 26.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        kmat[i][j] = hcm_pkg::mod26_key(key_r[i][5*j +: 5]);
      end
    end
  end

  // Matrix position of the current step.
  always_comb begin
    case (cmd.idx)
      4'd0:    begin ci = 2'd0; cj = 2'd0; end
      4'd1:    begin ci = 2'd0; cj = 2'd1; end
      4'd2:    begin ci = 2'd0; cj = 2'd2; end
      4'd3:    begin ci = 2'd1; cj = 2'd0; end
      4'd4:    begin ci = 2'd1; cj = 2'd1; end
      4'd5:    begin ci = 2'd1; cj = 2'd2; end
      4'd6:    begin ci = 2'd2; cj = 2'd0; end
      4'd7:    begin ci = 2'd2; cj = 2'd1; end
      4'd8:    begin ci = 2'd2; cj = 2'd2; end
      default: begin ci = 2'd0; cj = 2'd0; end
    endcase
  end

  // Rows and columns of the 2x2 minor that belongs to position (ci, cj).
  always_comb begin
    r0   = (ci == 2'd0) ? 2'd1 : 2'd0;
    r1   = (ci == 2'd2) ? 2'd1 : 2'd2;
    c0   = (cj == 2'd0) ? 2'd1 : 2'd0;
    c1   = (cj == 2'd2) ? 2'd1 : 2'd2;
    even = ~(ci[0] ^ cj[0]);
    ka   = kmat[r0][c0];
    kb   = kmat[r0][c1];
    kc   = kmat[r1][c0];
    kd   = kmat[r1][c1];
    row  = cmd.idx[1:0];
  end

  // Operand selection for the shared dot-product unit. A subtraction is
  // folded in as a product with the additive inverse of one factor, and an
  // odd cofactor swaps which product is negated.
  always_comb begin
    a0 = '0; b0 = '0; a1 = '0; b1 = '0; a2 = '0; b2 = '0;
    case (cmd.op)
      hcm_pkg::OP_COF: begin
        if (even) begin
          a0 = ka; b0 = kd; a1 = kb; b1 = hcm_pkg::neg26(kc);
        end else begin
          a0 = kb; b0 = kc; a1 = ka; b1 = hcm_pkg::neg26(kd);
        end
      end
      hcm_pkg::OP_DET: begin
        a0 = kmat[0][0]; b0 = cof_r[0][0];
        a1 = kmat[0][1]; b1 = cof_r[0][1];
        a2 = kmat[0][2]; b2 = cof_r[0][2];
      end
      hcm_pkg::OP_INV: begin
        a0 = cof_r[cj][ci]; b0 = dinv_r;
      end
      hcm_pkg::OP_ROW: begin
        a0 = dec_r ? inv_r[row][0] : kmat[row][0]; b0 = vec_r[0];
        a1 = dec_r ? inv_r[row][1] : kmat[row][1]; b1 = vec_r[1];
        a2 = dec_r ? inv_r[row][2] : kmat[row][2]; b2 = vec_r[2];
      end
      default: ;
    endcase
  end

  // Three small products and their sum.
  always_comb begin
    p0      = 10'(a0) * 10'(b0);
    p1      = 10'(a1) * 10'(b1);
    p2      = 10'(a2) * 10'(b2);
    sum_nxt = 11'(p0) + 11'(p1) + 11'(p2);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      sum_r <= sum_nxt;
    end
  end

  assign red  = hcm_pkg::mod26_sum(sum_r);
  assign cval = hcm_pkg::char_value(in_data.char_in);

  // Matrix results written back by the reduce step.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.op)
        hcm_pkg::OP_COF: cof_r[ci][cj] <= red;
        hcm_pkg::OP_DET: dinv_r        <= hcm_pkg::inv26(red);
        hcm_pkg::OP_INV: inv_r[ci][cj] <= red;
        default: ;
      endcase
    end
  end

  // Invertibility flag of the last determinant.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_ok_r <= 1'b0;
    end else if (cmd.store && cmd.op == hcm_pkg::OP_DET) begin
      inv_ok_r <= (hcm_pkg::inv26(red) != '0);
    end
  end

  // Gathered values and the block vector, padded with X where short.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r[0] <= '0;
      pend_r[1] <= '0;
    end else if (cmd.pend_wr) begin
      pend_r[cmd.cnt[0]] <= cval;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_ld) begin
      vec_r[0] <= (cmd.cnt == 2'd0) ? cval : pend_r[0];
      vec_r[1] <= (cmd.cnt == hcm_pkg::CNT_FULL) ? pend_r[1] :
                  (cmd.cnt == 2'd1) ? cval : hcm_pkg::PAD_VAL;
      vec_r[2] <= (cmd.cnt == hcm_pkg::CNT_FULL) ? cval : hcm_pkg::PAD_VAL;
      last_r   <= in_data.last_char;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_err) begin
        out_r.char_out  <= '0;
        out_r.last_out  <= 1'b1;
        out_r.key_error <= 1'b1;
      end else begin
        out_r.char_out  <= 7'(red) + hcm_pkg::OUT_A;
        out_r.last_out  <= last_r && (cmd.idx == hcm_pkg::IDX_LAST_ROW);
        out_r.key_error <= 1'b0;
      end
    end
  end

  assign out_data    = out_r;
  assign sts.decrypt = dec_r;
  assign sts.usable  = !dec_r || inv_ok_r;

endmodule

/* design/hcm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcm_ctrl: sequencing controller
// Rebuilds the working matrix after a key change, accepts characters,
// counts gathered values and steps the datapath through the three output
// rows of each block.
// ----------------------------------------------------------------------------
module hcm_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hcm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  hcm_pkg::dp_sts_t              sts,
  output hcm_pkg::dp_cmd_t              cmd
);

  hcm_pkg::ctl_state_t          state_r, state_nxt;
  logic [hcm_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [1:0]                   cnt_r, cnt_nxt;
  logic                         rdy_r, rdy_nxt;
  logic                         out_vld_r, out_vld_nxt;
  logic                         cfg_hit;
  logic                         accept;
  logic                         free;
  logic                         gather;

  // A write to a listed register invalidates the working matrix.
  assign cfg_hit = cfg_we && (cfg_index == hcm_pkg::REG_KEY_ROW0 ||
                              cfg_index == hcm_pkg::REG_KEY_ROW1 ||
                              cfg_index == hcm_pkg::REG_KEY_ROW2 ||
                              cfg_index == hcm_pkg::REG_DECRYPT_MODE);
  assign accept  = (state_r == hcm_pkg::S_IDLE) && rdy_r && in_valid;
  assign free    = !out_vld_r || !out_stall;
  assign gather  = (cnt_r != hcm_pkg::CNT_FULL) && !in_data.last_char;

  // Next state and counters.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    rdy_nxt     = rdy_r;
    out_vld_nxt = out_vld_r;
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
    case (state_r)
      hcm_pkg::S_IDLE: begin
        if (!rdy_r) begin
          if (sts.decrypt) begin
            state_nxt = hcm_pkg::S_COF_CALC;
            idx_nxt   = '0;
          end else begin
            rdy_nxt = 1'b1;
          end
        end else if (accept) begin
          if (!sts.usable) begin
            if (in_data.last_char) begin
              cnt_nxt   = '0;
              state_nxt = hcm_pkg::S_ERR_OUT;
            end
          end else if (gather) begin
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            cnt_nxt   = '0;
            idx_nxt   = '0;
            state_nxt = hcm_pkg::S_ROW_CALC;
          end
        end
      end
      hcm_pkg::S_COF_CALC: state_nxt = hcm_pkg::S_COF_STORE;
      hcm_pkg::S_COF_STORE: begin
        if (idx_r == hcm_pkg::IDX_LAST_ENTRY) begin
          idx_nxt   = '0;
          state_nxt = hcm_pkg::S_DET_CALC;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = hcm_pkg::S_COF_CALC;
        end
      end
      hcm_pkg::S_DET_CALC:  state_nxt = hcm_pkg::S_DET_STORE;
      hcm_pkg::S_DET_STORE: begin
        idx_nxt   = '0;
        state_nxt = hcm_pkg::S_INV_CALC;
      end
      hcm_pkg::S_INV_CALC:  state_nxt = hcm_pkg::S_INV_STORE;
      hcm_pkg::S_INV_STORE: begin
        if (idx_r == hcm_pkg::IDX_LAST_ENTRY) begin
          rdy_nxt   = 1'b1;
          state_nxt = hcm_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = hcm_pkg::S_INV_CALC;
        end
      end
      hcm_pkg::S_ROW_CALC:  state_nxt = hcm_pkg::S_ROW_STORE;
      hcm_pkg::S_ROW_STORE: begin
        if (free) begin
          if (idx_r == hcm_pkg::IDX_LAST_ROW) begin
            state_nxt = hcm_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_r + 4'd1;
            state_nxt = hcm_pkg::S_ROW_CALC;
          end
        end
      end
      hcm_pkg::S_ERR_OUT: begin
        if (free) begin
          state_nxt = hcm_pkg::S_IDLE;
        end
      end
      default: state_nxt = hcm_pkg::S_IDLE;
    endcase
    // A key change restarts any matrix build in progress.
    if (cfg_hit) begin
      rdy_nxt = 1'b0;
      if (!(state_r inside {hcm_pkg::S_ROW_CALC, hcm_pkg::S_ROW_STORE,
                            hcm_pkg::S_ERR_OUT})) begin
        state_nxt = hcm_pkg::S_IDLE;
      end
    end
  end

  // Datapath commands and handshake outputs.
  always_comb begin
    cmd          = '0;
    cmd.idx      = idx_r;
    cmd.cnt      = cnt_r;
    cmd.op       = hcm_pkg::OP_ROW;
    case (state_r)
      hcm_pkg::S_COF_CALC: begin
        cmd.op   = hcm_pkg::OP_COF;
        cmd.calc = 1'b1;
      end
      hcm_pkg::S_COF_STORE: begin
        cmd.op    = hcm_pkg::OP_COF;
        cmd.store = 1'b1;
      end
      hcm_pkg::S_DET_CALC: begin
        cmd.op   = hcm_pkg::OP_DET;
        cmd.calc = 1'b1;
      end
      hcm_pkg::S_DET_STORE: begin
        cmd.op    = hcm_pkg::OP_DET;
        cmd.store = 1'b1;
      end
      hcm_pkg::S_INV_CALC: begin
        cmd.op   = hcm_pkg::OP_INV;
        cmd.calc = 1'b1;
      end
      hcm_pkg::S_INV_STORE: begin
        cmd.op    = hcm_pkg::OP_INV;
        cmd.store = 1'b1;
      end
      hcm_pkg::S_ROW_CALC: begin
        cmd.calc = 1'b1;
      end
      hcm_pkg::S_ROW_STORE: begin
        cmd.store    = free;
        cmd.out_load = free;
      end
      hcm_pkg::S_ERR_OUT: begin
        cmd.out_load = free;
        cmd.out_err  = 1'b1;
      end
      hcm_pkg::S_IDLE: begin
        cmd.pend_wr = accept && sts.usable && gather;
        cmd.blk_ld  = accept && sts.usable && !gather;
      end
      default: ;
    endcase
    in_stall  = !((state_r == hcm_pkg::S_IDLE) && rdy_r);
    out_valid = out_vld_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hcm_pkg::S_IDLE;
      idx_r     <= '0;
      cnt_r     <= '0;
      rdy_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cnt_r     <= cnt_nxt;
      rdy_r     <= rdy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // The gathered count never passes two values.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("pending count out of range");

  // The matrix becomes ready only in encrypt mode from idle or after the
  // last inverse entry.
  a_rdy_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rdy_r) |-> ($past(state_r) == hcm_pkg::S_IDLE ||
                      $past(state_r) == hcm_pkg::S_INV_STORE))
    else $error("matrix marked ready from an unexpected state");

  // After the third row of a block goes out, the controller is idle.
  a_blk_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcm_pkg::S_ROW_STORE && idx_r == hcm_pkg::IDX_LAST_ROW && free)
    |=> state_r == hcm_pkg::S_IDLE)
    else $error("block did not finish after the third row");

  // An error result drops the gathered values.
  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hcm_pkg::S_ERR_OUT |-> cnt_r == 2'd0)
    else $error("gathered values kept across an error result");

endmodule

/* design/hill_cipher_3x3_mod26.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_3x3_mod26: 3x3 Hill cipher modulo 26
// Encrypts with the key matrix or decrypts with its mod-26 inverse, three
// characters to a block, padding a short final block with X.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_wdata
//   in       in         in_valid / in_stall  in_data (char_in, last_char)
//   out      out        out_valid/out_stall  out_data (char_out, last_out,
//                                            key_error)
//
// A character that does not complete a block is taken while the block stays
// idle. One that completes or ends a block starts the three output rows,
// each formed by the shared dot-product unit in a calc and a store step; the
// store step waits on output stalls. The last character under a singular
// decrypt key starts an error result, which also waits on output stalls.
// After reset or any key or mode write the working matrix is rebuilt before
// characters are taken: in encrypt mode by an idle step alone, in decrypt
// mode by an idle step, then nine cofactors, the determinant and nine inverse
// entries, each in a calc and a store step.
// A finished result waits in the output register while the next character
// is taken; out_stall holds only the step that needs that register.
// ----------------------------------------------------------------------------
module hill_cipher_3x3_mod26 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hcm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hcm_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hcm_pkg::out_item_t             out_data
);

  hcm_pkg::dp_cmd_t cmd;
  hcm_pkg::dp_sts_t sts;

  // Sequencing controller.
  hcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Key storage, matrix arithmetic and output register.
  hcm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 mod-26 Hill cipher
// Drives character streams through the valid/stall input channel under
// random key and mode settings, predicts every output letter and key error
// in a small scoreboard class, and compares each accepted result in order.
// Both channels idle at random, with one stretch of no idling and one long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import hcm_pkg::*;

  localparam int unsigned RADIX       = MOD_BASE;
  localparam int unsigned IDLE_PCT    = 29;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned TAIL        = 50;
  localparam int unsigned STUCK_LIMIT = 3000;
  localparam int unsigned RAND_ITEMS  = 300;
  localparam logic [CFG_DATA_W-1:0] ROW_ALL_ONES = '1;

  // Predicts the letters the cipher emits and checks them in arrival order.
  class hill_checker;
    logic [CFG_DATA_W-1:0] key_row[3];
    bit                    decrypt;
    int unsigned           held_vals[2];
    int unsigned           held_count;
    int unsigned           work_mat[9];
    bit                    mat_built;
    bit                    mat_usable;
    out_item_t             letters_due[$];
    int unsigned           mismatches;

    function new();
      key_row    = '{default: '0};
      decrypt    = 1'b0;
      held_vals  = '{default: 0};
      held_count = 0;
      work_mat   = '{default: 0};
      mat_built  = 1'b0;
      mat_usable = 1'b0;
      mismatches = 0;
    endfunction

    // Any valid register write forces a matrix rebuild; others are ignored.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < REG_DECRYPT_MODE) begin
        key_row[idx] = data;
        mat_built    = 1'b0;
      end else if (idx == REG_DECRYPT_MODE) begin
        decrypt   = data[0];
        mat_built = 1'b0;
      end
    endfunction

    // Key matrix for encryption, or its mod-26 inverse for decryption.
    function void rebuild_matrix();
      int unsigned k[9];
      int unsigned cof[9];
      int unsigned det, dinv;
      int          i1, i2, j1, j2;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          k[i*3+j] = ((key_row[i] >> (5 * j)) & 31) % RADIX;
        end
      end
      if (!decrypt) begin
        work_mat   = k;
        mat_usable = 1'b1;
      end else begin
        // Cyclic minors of a 3x3 already carry the cofactor sign.
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            j1 = (j + 1) % 3;
            j2 = (j + 2) % 3;
            cof[i*3+j] = (k[i1*3+j1] * k[i2*3+j2] + RADIX * RADIX
                          - k[i1*3+j2] * k[i2*3+j1]) % RADIX;
          end
        end
        det  = (k[0] * cof[0] + k[1] * cof[1] + k[2] * cof[2]) % RADIX;
        dinv = 0;
        for (int d = 1; d < RADIX; d++) begin
          if ((det * d) % RADIX == 1) begin
            dinv = d;
          end
        end
        if (dinv == 0) begin
          work_mat   = '{default: 0};
          mat_usable = 1'b0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              work_mat[i*3+j] = (cof[j*3+i] * dinv) % RADIX;
            end
          end
          mat_usable = 1'b1;
        end
      end
      mat_built = 1'b1;
    endfunction

    // Notes one accepted character and queues the letters it produces.
    function void predict_char(in_item_t t);
      int unsigned v, n, s;
      int unsigned vec[3];
      out_item_t   e;
      if (!mat_built) begin
        rebuild_matrix();
      end
      // A singular decrypt key yields only an error result on the last character.
      if (!mat_usable) begin
        if (t.last_char) begin
          held_count  = 0;
          e.char_out  = '0;
          e.last_out  = 1'b1;
          e.key_error = 1'b1;
          letters_due.push_back(e);
        end
        return;
      end
      v = (t.char_in >= ASCII_A && t.char_in <= ASCII_Z) ?
          t.char_in - ASCII_A : t.char_in % CHAR_MOD;
      n = held_count;
      if (n < 2 && !t.last_char) begin
        held_vals[n] = v;
        held_count   = n + 1;
        return;
      end
      // Complete the block, padding a short final one with X.
      for (int x = 0; x < 3; x++) begin
        vec[x] = (x < n) ? held_vals[x] : (x == n) ? v : PAD_VAL;
      end
      for (int r = 0; r < 3; r++) begin
        s = 0;
        for (int x = 0; x < 3; x++) begin
          s += work_mat[r*3+x] * vec[x];
        end
        e.char_out  = CHAR_OUT_W'(s % RADIX + OUT_A);
        e.last_out  = t.last_char && (r == 2);
        e.key_error = 1'b0;
        letters_due.push_back(e);
      end
      held_count = 0;
    endfunction

    // Compares one accepted result against the oldest prediction.
    function void check_letter(out_item_t got);
      out_item_t want;
      if (letters_due.size() == 0) begin
        $error("unexpected result: char_out %0d last_out %0d key_error %0d",
               got.char_out, got.last_out, got.key_error);
        mismatches++;
        return;
      end
      want = letters_due.pop_front();
      // The letter carries no meaning on an error result.
      if (!want.key_error && got.char_out !== want.char_out) begin
        $error("char_out: expected %0d, actual %0d", want.char_out, got.char_out);
        mismatches++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0d, actual %0d", want.last_out, got.last_out);
        mismatches++;
      end
      if (got.key_error !== want.key_error) begin
        $error("key_error: expected %0d, actual %0d", want.key_error, got.key_error);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return letters_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  hill_checker sb;
  bit          quiet;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned stuck_cycles;
  int unsigned chars_sent;

  hill_cipher_3x3_mod26 uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  // Receiver: random stalls, a no-idle stretch, and one long hold-off.
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Transaction monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.predict_char(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_letter(out_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [CFG_DATA_W-1:0] pack_row(logic [4:0] c0, logic [4:0] c1,
                                                     logic [4:0] c2);
    return {c2, c1, c0};
  endfunction

  // Offers one character, with random idle cycles ahead of it.
  task automatic send_char(logic [CHAR_IN_W-1:0] c, logic last);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
        @(posedge clk);
      end
    end
    in_valid          <= 1'b1;
    in_data.char_in   <= c;
    in_data.last_char <= last;
    do begin
      @(posedge clk);
    end while (in_stall);
    chars_sent++;
  endtask

  task automatic send_text(string s, logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  // Waits until every predicted letter has arrived and the block is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
  endtask

  // Write to an unused index; the block must ignore it.
  task automatic cfg_junk();
    cfg_write(CFG_IDX_W'(REG_DECRYPT_MODE) + CFG_IDX_W'($urandom_range(1, 4)),
              CFG_DATA_W'($urandom));
  endtask

  // Picks a key and mode for one random phase and writes them.
  task automatic random_setting();
    logic [CFG_DATA_W-1:0] rows[3];
    int unsigned           m[9];
    int unsigned           style, p, q, r, d;
    style = $urandom_range(9);
    if (style <= 5) begin
      // Upper triangular with units on the diagonal, then determinant-
      // preserving row operations so that the key stays invertible.
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          d = 2 * $urandom_range(12) + 1;
          if (d == RADIX / 2) begin
            d = 1;
          end
          m[i*3+j] = (j > i) ? $urandom_range(RADIX - 1) : (j == i) ? d : 0;
        end
      end
      p = $urandom_range(RADIX - 1);
      q = $urandom_range(RADIX - 1);
      r = $urandom_range(RADIX - 1);
      for (int j = 0; j < 3; j++) begin
        m[3+j] = (m[3+j] + p * m[j]) % RADIX;
        m[6+j] = (m[6+j] + q * m[3+j]) % RADIX;
        m[j]   = (m[j] + r * m[6+j]) % RADIX;
      end
      // Small entries sometimes go in with 26 added on top.
      for (int x = 0; x < 9; x++) begin
        if (m[x] < 32 - RADIX && $urandom_range(1) == 1) begin
          m[x] += RADIX;
        end
      end
      for (int i = 0; i < 3; i++) begin
        rows[i] = pack_row(5'(m[i*3]), 5'(m[i*3+1]), 5'(m[i*3+2]));
      end
    end else if (style == 6) begin
      for (int i = 0; i < 3; i++) begin
        rows[i] = CFG_DATA_W'($urandom);
      end
    end else if (style == 7) begin
      rows = '{ROW_ALL_ONES, ROW_ALL_ONES, ROW_ALL_ONES};
    end else if (style == 8) begin
      rows = '{default: '0};
    end else begin
      rows = '{pack_row(1, 0, 0), pack_row(0, 1, 0), pack_row(0, 0, 1)};
    end
    if ($urandom_range(4) != 0) begin
      cfg_write(REG_KEY_ROW0, rows[0]);
      cfg_write(REG_KEY_ROW1, rows[1]);
      cfg_write(REG_KEY_ROW2, rows[2]);
    end
    cfg_write(REG_DECRYPT_MODE, CFG_DATA_W'($urandom_range(1)));
    if ($urandom_range(3) == 0) begin
      cfg_junk();
    end
    cfg_done();
  endtask

  // Random messages; most end with a last character, a few are left open.
  task automatic random_messages(int unsigned amount);
    int unsigned len, goal;
    logic [CHAR_IN_W-1:0] c;
    goal = chars_sent + amount;
    while (chars_sent < goal) begin
      len = $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 70) begin
          c = ASCII_A + CHAR_IN_W'($urandom_range(RADIX - 1));
        end else begin
          c = CHAR_IN_W'($urandom_range(255));
        end
        send_char(c, (i == len - 1) && ($urandom_range(99) < 90));
      end
    end
  endtask

  initial begin
    int unsigned phase;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    hold_left = 0;
    stuck_cycles = 0;
    chars_sent   = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset key of all zeros in encrypt mode: a lone last character.
    send_char("Q", 1'b1);
    drain();

    // Classic invertible key, encrypt mode.
    cfg_write(REG_KEY_ROW0, pack_row(6, 24, 1));
    cfg_write(REG_KEY_ROW1, pack_row(13, 16, 10));
    cfg_write(REG_KEY_ROW2, pack_row(20, 17, 15));
    cfg_write(REG_DECRYPT_MODE, '0);
    cfg_done();
    send_text("ACT", 1'b0);
    // Byte extremes and a lower-case letter form one block.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h61, 1'b0);
    // Last character after one held value, then as the only value.
    send_char(8'h60, 1'b0);
    send_char("Z", 1'b1);
    send_char("M", 1'b1);
    // Last character that completes a full block.
    send_char(CHAR_MOD, 1'b0);
    send_char("Y", 1'b0);
    send_char("B", 1'b1);
    // One value stays held across the mode change.
    send_char("K", 1'b0);
    drain();

    // Decrypt with the inverse of the same key.
    cfg_write(REG_DECRYPT_MODE, CFG_DATA_W'(1));
    cfg_done();
    send_text("PO", 1'b0);
    send_text("POH", 1'b1);
    drain();

    // Entries above 25 reduce to a singular matrix: decrypt gives a key error.
    cfg_write(REG_KEY_ROW0, ROW_ALL_ONES);
    cfg_write(REG_KEY_ROW1, ROW_ALL_ONES);
    cfg_write(REG_KEY_ROW2, ROW_ALL_ONES);
    cfg_junk();
    cfg_done();
    send_text("AB", 1'b0);
    send_char("C", 1'b1);
    drain();

    // The same singular key still encrypts.
    cfg_write(REG_DECRYPT_MODE, '0);
    cfg_done();
    send_text("ABC", 1'b1);
    drain();

    // Random phases, one without idling and one with a long receiver hold-off.
    phase = 0;
    chars_sent = 0;
    while (chars_sent < RAND_ITEMS) begin
      phase++;
      random_setting();
      quiet = (phase == 2);
      if (phase == 4) begin
        hold_req = 1'b1;
      end
      random_messages(30 + $urandom_range(20));
      drain();
      quiet = 1'b0;
    end

    drain();
    repeat (TAIL) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
